// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the clipper rtl, included by phc_back
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("clipper assertion failed");
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("clipper forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- hw/rtl/phc_pkg.sv -----
// ---------------------------------------------------------------------------
// phc_pkg
// types, constants and helpers shared by the half-space clipper modules
// ---------------------------------------------------------------------------
package phc_pkg;

    localparam int CW    = 32;           // coordinate width
    localparam int FB    = 16;           // fraction bits
    localparam int TW    = 16;           // tolerance width
    localparam int MW    = 2 * CW + 3;   // dot product accumulator width
    localparam int DW    = MW - FB;      // distance width
    localparam int CMW   = DW + 1;       // divisor magnitude width
    localparam int RW    = DW + 3;       // partial remainder width
    localparam int IW    = 3;            // register index width
    localparam int QW    = CW + 1;       // quotient and dividend width
    localparam int DIV_STEPS = QW;

    localparam logic [CW-1:0] NORMAL_Z_RESET = CW'(64'd1 << FB);
    localparam logic [TW-1:0] TOL_RESET      = TW'((64'd1 << FB) / 100);

    typedef enum logic [IW-1:0] {
        REG_PLANE_X  = 3'd0,
        REG_PLANE_Y  = 3'd1,
        REG_PLANE_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_TOL      = 3'd6
    } reg_idx_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        coord_t vertex_x;
        coord_t vertex_y;
        coord_t vertex_z;
        logic   closes_polygon;
    } in_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   is_crossing;
        logic   vertex_valid;
        logic   run_last;
        logic   polygon_end;
    } out_t;

    // work still to be done for one classified vertex
    typedef struct packed {
        logic marker;
        logic cross_close;
        logic keep;
        logic cross_prev;
    } steps_t;

    typedef struct packed {
        vec_t   cur_v;
        dist_t  cur_d;
        vec_t   prv_v;
        dist_t  prv_d;
        vec_t   fst_v;
        dist_t  fst_d;
        steps_t steps;
        logic   closing;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_CLASS
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PICK,
        B_SETUP,
        B_ABS,
        B_DIV,
        B_EMIT
    } back_state_t;

    function automatic dist_t tol_dist(logic [TW-1:0] tol);
        return dist_t'({{(DW-TW){1'b0}}, tol});
    endfunction

    function automatic logic is_below(dist_t d, logic [TW-1:0] tol);
        return d < -tol_dist(tol);
    endfunction

    function automatic logic is_above(dist_t d, logic [TW-1:0] tol);
        return d > tol_dist(tol);
    endfunction

    function automatic logic crosses(dist_t dp, dist_t dc, logic [TW-1:0] tol);
        return (is_below(dp, tol) && is_above(dc, tol))
            || (is_below(dc, tol) && is_above(dp, tol));
    endfunction

    function automatic coord_t lane_of(vec_t v, int k);
        coord_t r;
        case (k)
            0:       r = v.x;
            1:       r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/phc_front.sv -----
// ---------------------------------------------------------------------------
// phc_front
// takes vertices, forms the plane distance and classifies each vertex
// ---------------------------------------------------------------------------
module phc_front
    import phc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  in_t             item,
    input  logic            write_enable,
    input  logic [IW-1:0]   write_index,
    input  logic [CW-1:0]   write_data,
    output job_t            job,
    output logic            job_push,
    input  logic            job_full
);

    front_state_t           state_reg, state_next;
    logic [1:0]             cnt_reg;
    vec_t                   plane_reg, normal_reg;
    logic [TW-1:0]          tol_reg;
    vec_t                   cur_reg, first_reg, prior_reg;
    logic                   closing_reg;
    dist_t                  fdist_reg, pdist_reg;
    logic                   have_first_reg;
    logic signed [2*CW:0]   prod_reg;
    logic signed [MW-1:0]   acc_reg;

    logic signed [CW:0]     mul_a;
    coord_t                 mul_b;
    logic signed [2*CW:0]   mul_p;
    logic                   accept;
    dist_t                  cur_d;
    steps_t                 steps;

    assign accept = push && !full;
    assign full   = (state_reg != F_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= '0;
            normal_reg <= '{x: '0, y: '0, z: NORMAL_Z_RESET};
            tol_reg    <= TOL_RESET;
        end
        else if (write_enable)
        begin
            case (reg_idx_t'(write_index))
                REG_PLANE_X:  plane_reg.x  <= write_data;
                REG_PLANE_Y:  plane_reg.y  <= write_data;
                REG_PLANE_Z:  plane_reg.z  <= write_data;
                REG_NORMAL_X: normal_reg.x <= write_data;
                REG_NORMAL_Y: normal_reg.y <= write_data;
                REG_NORMAL_Z: normal_reg.z <= write_data;
                REG_TOL:      tol_reg      <= write_data[TW-1:0];
                default:      ;
            endcase
        end
    end

    // one coordinate term of the dot product per cycle
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = $signed({cur_reg.x[CW-1], cur_reg.x})
                      - $signed({plane_reg.x[CW-1], plane_reg.x});
                mul_b = normal_reg.x;
            end
            2'd1:
            begin
                mul_a = $signed({cur_reg.y[CW-1], cur_reg.y})
                      - $signed({plane_reg.y[CW-1], plane_reg.y});
                mul_b = normal_reg.y;
            end
            default:
            begin
                mul_a = $signed({cur_reg.z[CW-1], cur_reg.z})
                      - $signed({plane_reg.z[CW-1], plane_reg.z});
                mul_b = normal_reg.z;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // classification of the finished distance
    always_comb
    begin
        cur_d = dist_t'(acc_reg[MW-1:FB]);
        job.cur_v   = cur_reg;
        job.cur_d   = cur_d;
        job.prv_v   = prior_reg;
        job.prv_d   = pdist_reg;
        job.fst_v   = have_first_reg ? first_reg : cur_reg;
        job.fst_d   = have_first_reg ? fdist_reg : cur_d;
        job.closing = closing_reg;
        steps.cross_prev  = have_first_reg && crosses(pdist_reg, cur_d, tol_reg);
        steps.keep        = !is_below(cur_d, tol_reg);
        steps.cross_close = closing_reg && crosses(cur_d, job.fst_d, tol_reg);
        steps.marker      = closing_reg && !steps.cross_prev && !steps.keep
                         && !steps.cross_close;
        job.steps = steps;
    end

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_push   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_MUL;
            end
            F_MUL:
            begin
                if (cnt_reg == 2'd3)
                    state_next = F_CLASS;
            end
            F_CLASS:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    // polygon tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_first_reg <= 1'b0;
        else if (job_push)
            have_first_reg <= !closing_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg     <= '{x: item.vertex_x, y: item.vertex_y, z: item.vertex_z};
            closing_reg <= item.closes_polygon;
            cnt_reg     <= 2'd0;
            acc_reg     <= '0;
        end
        else if (state_reg == F_MUL)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg != 2'd3)
                prod_reg <= mul_p;
            if (cnt_reg != 2'd0)
                acc_reg <= acc_reg + MW'(prod_reg);
        end
        if (job_push)
        begin
            prior_reg <= cur_reg;
            pdist_reg <= cur_d;
            if (!have_first_reg)
            begin
                first_reg <= cur_reg;
                fdist_reg <= cur_d;
            end
        end
    end

endmodule

// ----- hw/rtl/phc_queue.sv -----
// ---------------------------------------------------------------------------
// phc_queue
// short queue of classified vertices between front and back
// ---------------------------------------------------------------------------
module phc_queue
    import phc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    output logic full,
    input  logic rd,
    output job_t rd_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_job = slot_reg[rptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wptr_reg <= !wptr_reg;
            if (rd)
                rptr_reg <= !rptr_reg;
            if (wr && !rd)
                count_reg <= count_reg + 2'd1;
            else if (rd && !wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wptr_reg] <= wr_job;
    end

endmodule

// ----- hw/rtl/phc_back.sv -----
// ---------------------------------------------------------------------------
// phc_back
// runs the queued steps: crossings through a three-lane divider, then results
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module phc_back
    import phc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t q_job,
    input  logic q_empty,
    output logic q_pop,
    output out_t result,
    output logic empty,
    input  logic pop
);

    back_state_t            state_reg, state_next;
    job_t                   job_reg;
    steps_t                 pend_reg;
    logic                   sel_close_reg;
    logic                   emit_cross_reg, emit_valid_reg;
    vec_t                   emit_v_reg;
    vec_t                   pv_reg;
    logic signed [CW:0]     diff_reg [3];
    logic signed [DW:0]     den_reg;
    logic                   dpneg_reg;
    logic [DW-1:0]          b_reg;
    logic [CMW-1:0]         c_reg;
    logic [QW-1:0]          a_reg [3];
    logic [QW-1:0]          q_reg [3];
    logic [CMW-1:0]         r_reg [3];
    logic                   neg_reg [3];
    logic [5:0]             cnt_reg;
    out_t                   out_reg;
    logic                   out_full_reg;

    logic                   load_out;
    logic                   div_done;
    logic                   start_cross, close_sel;
    steps_t                 pend_clear;
    vec_t                   op_pv, op_cv;
    dist_t                  op_dp, op_dc;
    logic [RW-1:0]          r2 [3];
    logic [RW-1:0]          c1, c2;
    logic [CMW-1:0]         r_step [3];
    logic [QW-1:0]          q_step [3];
    logic [QW:0]            x_lane [3];
    out_t                   out_d;

    assign empty    = !out_full_reg;
    assign result   = out_reg;
    assign div_done = (cnt_reg == 6'(DIV_STEPS - 1));

    // operand selection for the edge being cut
    always_comb
    begin
        op_pv = sel_close_reg ? job_reg.cur_v : job_reg.prv_v;
        op_dp = sel_close_reg ? job_reg.cur_d : job_reg.prv_d;
        op_cv = sel_close_reg ? job_reg.fst_v : job_reg.cur_v;
        op_dc = sel_close_reg ? job_reg.fst_d : job_reg.cur_d;
    end

    // one quotient digit (0, 1 or 2) per lane and cycle; remainder stays below the divisor
    always_comb
    begin
        c1 = RW'(c_reg);
        c2 = RW'(c_reg) << 1;
        for (int k = 0; k < 3; k++)
        begin
            r2[k] = (RW'(r_reg[k]) << 1) + (a_reg[k][QW-1] ? RW'(b_reg) : '0);
            if (r2[k] >= c2)
            begin
                r_step[k] = CMW'(r2[k] - c2);
                q_step[k] = (q_reg[k] << 1) + QW'(2);
            end
            else if (r2[k] >= c1)
            begin
                r_step[k] = CMW'(r2[k] - c1);
                q_step[k] = (q_reg[k] << 1) + QW'(1);
            end
            else
            begin
                r_step[k] = CMW'(r2[k]);
                q_step[k] = q_reg[k] << 1;
            end
        end
    end

    // result assembly
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (neg_reg[k])
                x_lane[k] = (QW+1)'($signed(lane_of(pv_reg, k))) + (QW+1)'(q_reg[k]);
            else
                x_lane[k] = (QW+1)'($signed(lane_of(pv_reg, k))) - (QW+1)'(q_reg[k]);
        end
        if (emit_cross_reg)
        begin
            out_d.out_x = x_lane[0][CW-1:0];
            out_d.out_y = x_lane[1][CW-1:0];
            out_d.out_z = x_lane[2][CW-1:0];
        end
        else
        begin
            out_d.out_x = emit_v_reg.x;
            out_d.out_y = emit_v_reg.y;
            out_d.out_z = emit_v_reg.z;
        end
        out_d.is_crossing  = emit_cross_reg;
        out_d.vertex_valid = emit_valid_reg;
        out_d.run_last     = (pend_reg == '0);
        out_d.polygon_end  = (pend_reg == '0) && job_reg.closing;
    end

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        start_cross = 1'b0;
        close_sel   = 1'b0;
        pend_clear  = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_PICK;
                end
            end
            B_PICK:
            begin
                if (pend_reg.cross_prev)
                begin
                    pend_clear.cross_prev = 1'b1;
                    start_cross = 1'b1;
                    state_next  = B_SETUP;
                end
                else if (pend_reg.keep)
                begin
                    pend_clear.keep = 1'b1;
                    state_next = B_EMIT;
                end
                else if (pend_reg.cross_close)
                begin
                    pend_clear.cross_close = 1'b1;
                    start_cross = 1'b1;
                    close_sel   = 1'b1;
                    state_next  = B_SETUP;
                end
                else if (pend_reg.marker)
                begin
                    pend_clear.marker = 1'b1;
                    state_next = B_EMIT;
                end
                else
                    state_next = B_IDLE;
            end
            B_SETUP:
                state_next = B_ABS;
            B_ABS:
                state_next = B_DIV;
            B_DIV:
            begin
                if (div_done)
                    state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_full_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = B_PICK;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (load_out)
            out_full_reg <= 1'b1;
        else if (pop)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= out_d;
    end

    // step bookkeeping and divider datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg  <= q_job;
            pend_reg <= q_job.steps;
        end
        else if (state_reg == B_PICK)
        begin
            pend_reg       <= pend_reg & ~pend_clear;
            sel_close_reg  <= close_sel;
            emit_cross_reg <= start_cross;
            emit_valid_reg <= !pend_clear.marker;
            emit_v_reg     <= pend_clear.marker ? '0 : job_reg.cur_v;
        end
        if (state_reg == B_SETUP)
        begin
            pv_reg    <= op_pv;
            den_reg   <= $signed({op_dc[DW-1], op_dc}) - $signed({op_dp[DW-1], op_dp});
            dpneg_reg <= op_dp[DW-1];
            b_reg     <= op_dp[DW-1] ? DW'(-op_dp) : DW'(op_dp);
            for (int k = 0; k < 3; k++)
                diff_reg[k] <= (CW+1)'(lane_of(op_cv, k)) - (CW+1)'(lane_of(op_pv, k));
        end
        if (state_reg == B_ABS)
        begin
            c_reg   <= den_reg[DW] ? CMW'(-den_reg) : CMW'(den_reg);
            cnt_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k]   <= diff_reg[k][CW] ? QW'(-diff_reg[k]) : QW'(diff_reg[k]);
                neg_reg[k] <= diff_reg[k][CW] ^ dpneg_reg ^ den_reg[DW];
                r_reg[k]   <= '0;
                q_reg[k]   <= '0;
            end
        end
        if (state_reg == B_DIV)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= a_reg[k] << 1;
                r_reg[k] <= r_step[k];
                q_reg[k] <= q_step[k];
            end
        end
    end

    // checks
    `ASSERT_AT(a_out_no_overwrite, clk, rst_n, load_out |-> (!out_full_reg || pop))
    `ASSERT_AT(a_rem_below_div, clk, rst_n, (state_reg == B_DIV) |-> (r_reg[0] < c_reg))
    `ASSERT_AT(a_marker_ends, clk, rst_n, (out_full_reg && !out_reg.vertex_valid) |-> out_reg.polygon_end)
    `ASSERT_NEVER(a_pop_on_empty, clk, rst_n, q_pop && q_empty)

endmodule

// ----- hw/rtl/polygon_halfspace_clipper.sv -----
// ---------------------------------------------------------------------------
// polygon_halfspace_clipper
// clips a streamed polygon against one plane half-space
// ---------------------------------------------------------------------------
// front: three 33x32 products, one per cycle, then classify, held by a full queue
// back: kept/marker: pick, emit; crossing: pick, setup, abs, 33-step divider, emit
// each stage takes a new vertex only once it is through with the last one
// reset clears control state and loads the plane, normal and tolerance defaults
// ---------------------------------------------------------------------------
module polygon_halfspace_clipper
    import phc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  in_t             item,
    output logic            empty,
    input  logic            pop,
    output out_t            result,
    input  logic            write_enable,
    input  logic [IW-1:0]   write_index,
    input  logic [CW-1:0]   write_data
);

    job_t f_job, b_job;
    logic f_push, q_full, q_empty, b_pop;

    // classify vertices
    phc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .job          (f_job),
        .job_push     (f_push),
        .job_full     (q_full)
    );

    // decoupling queue
    phc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (f_push),
        .wr_job (f_job),
        .full   (q_full),
        .rd     (b_pop),
        .rd_job (b_job),
        .empty  (q_empty)
    );

    // crossings and results
    phc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (b_job),
        .q_empty (q_empty),
        .q_pop   (b_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
